// ----- rtl/core/ubd_pkg.sv -----
package ubd_pkg;

    typedef struct packed {
        logic        mode;
        logic [1:0]  channel_number;
        logic [23:0] line_rate;
        logic        two_stop_bits;
        logic [2:0]  parity_kind;
        logic [3:0]  data_bit_count;
    } ubd_in_t;

    typedef struct packed {
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic        valid_res;
    } ubd_out_t;

    localparam logic [23:0] HIGH_BAND_LIMIT = 24'd256000;
    localparam logic [8:0]  FACTOR_LIMIT    = 9'd255;
    localparam logic [7:0]  CODE_BASE       = 8'hA1;
    localparam logic [7:0]  CODE_HIGH_ADD   = 8'h0E;
    localparam logic [7:0]  CODE_MODEM_ADD  = 8'd3;
    localparam logic [7:0]  CTL_BASE        = 8'hC0;
    localparam logic [7:0]  VALUE_LOW       = 8'h8C;
    localparam logic [15:0] MODEM_VALUE     = 16'h0080;
    localparam logic        MODE_LINE       = 1'b0;

    localparam logic [2:0] BAND_0 = 3'd0;
    localparam logic [2:0] BAND_1 = 3'd1;
    localparam logic [2:0] BAND_2 = 3'd2;
    localparam logic [2:0] BAND_3 = 3'd3;
    localparam logic [2:0] BAND_7 = 3'd7;

    // item context carried alongside the divider
    typedef struct packed {
        logic        mode;
        logic [7:0]  code;
        logic [23:0] baud;
        logic [7:0]  ctl;
        logic [2:0]  band;
    } ubd_ctx_t;

    // context carried alongside the rounding divider
    typedef struct packed {
        ubd_ctx_t    ctx;
        logic        bad;
        logic [7:0]  q;
        logic [23:0] r;
    } ubd_rnd_t;

endpackage

// ----- rtl/core/ubd_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module ubd_div #(
    parameter int NW = 26,
    parameter int DW = 24,
    parameter int CW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [CW-1:0] in_ctx,
    output logic          out_vld,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [CW-1:0] out_ctx
);
    logic [NW-1:0] vld_reg;
    logic [NW-1:0] q_reg [NW+1];
    logic [DW-1:0] r_reg [NW+1];
    logic [DW-1:0] d_reg [NW+1];
    logic [CW-1:0] c_reg [NW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NW-2:0], in_vld};
    end

    always_comb
    begin
        q_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        c_reg[0] = in_ctx;
    end

    for (genvar i = 0; i < NW; i++) begin : g_st
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic [NW-1:0] q_s;
        logic [DW-1:0] r_s;
        logic [DW-1:0] d_s;
        logic [CW-1:0] c_s;
        assign trial = {r_reg[i], q_reg[i][NW-1]};
        assign diff  = trial - {1'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            d_s <= d_reg[i];
            c_s <= c_reg[i];
            if (!diff[DW])
            begin
                r_s <= diff[DW-1:0];
                q_s <= {q_reg[i][NW-2:0], 1'b1};
            end
            else
            begin
                r_s <= trial[DW-1:0];
                q_s <= {q_reg[i][NW-2:0], 1'b0};
            end
        end
        always_comb
        begin
            q_reg[i+1] = q_s;
            r_reg[i+1] = r_s;
            d_reg[i+1] = d_s;
            c_reg[i+1] = c_s;
        end
    end

    assign out_vld = vld_reg[NW-1];
    assign quo     = q_reg[NW];
    assign rem     = r_reg[NW];
    assign out_ctx = c_reg[NW];
endmodule

// ----- rtl/core/ubd_front.sv -----
// band choice and control byte, one register stage
module ubd_front #(
    parameter int BASE_CLOCK_HZ = 12000000
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  ubd_pkg::ubd_in_t din,
    output logic             out_vld,
    output ubd_pkg::ubd_ctx_t ctx,
    output logic [25:0]      clk_div
);
    import ubd_pkg::*;

    localparam logic [25:0] CLK7 = 26'(BASE_CLOCK_HZ);
    localparam logic [25:0] CLK3 = 26'(BASE_CLOCK_HZ / 2);
    localparam logic [25:0] CLK2 = 26'(BASE_CLOCK_HZ / 16);
    localparam logic [25:0] CLK1 = 26'(BASE_CLOCK_HZ / 128);
    localparam logic [25:0] CLK0 = 26'((BASE_CLOCK_HZ + 512) / 1024);
    localparam logic [23:0] LIM3 = 24'(BASE_CLOCK_HZ / 2 / 255);
    localparam logic [23:0] LIM2 = 24'(BASE_CLOCK_HZ / 16 / 255);
    localparam logic [23:0] LIM1 = 24'(BASE_CLOCK_HZ / 128 / 255);

    logic      vld_reg;
    ubd_ctx_t  ctx_reg, ctx_next;
    logic [25:0] clk_reg, clk_next;
    logic [7:0]  code;
    logic [2:0]  pm1;

    always_comb
    begin
        code = CODE_BASE + {6'd0, din.channel_number};
        if (din.channel_number[1])
            code = code + CODE_HIGH_ADD;
        pm1 = din.parity_kind - 3'd1;
        ctx_next.mode = din.mode;
        ctx_next.code = code;
        ctx_next.baud = din.line_rate;
        ctx_next.ctl  = CTL_BASE | {5'd0, din.two_stop_bits, 2'd0}
                      | {6'd0, 2'(din.data_bit_count - 4'd5)};
        if (din.parity_kind != 3'd0)
            ctx_next.ctl = ctx_next.ctl | {2'd0, pm1[1:0], 4'b1000};
        if (din.line_rate >= HIGH_BAND_LIMIT)
        begin
            ctx_next.band = BAND_7; clk_next = CLK7;
        end
        else if (din.line_rate > LIM3)
        begin
            ctx_next.band = BAND_3; clk_next = CLK3;
        end
        else if (din.line_rate > LIM2)
        begin
            ctx_next.band = BAND_2; clk_next = CLK2;
        end
        else if (din.line_rate > LIM1)
        begin
            ctx_next.band = BAND_1; clk_next = CLK1;
        end
        else
        begin
            ctx_next.band = BAND_0; clk_next = CLK0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
        clk_reg <= clk_next;
    end

    assign out_vld = vld_reg;
    assign ctx     = ctx_reg;
    assign clk_div = clk_reg;
endmodule

// ----- rtl/core/ubd_back.sv -----
// rounding and packing of the result word
// rounding test: clk/q - b > b - clk/(q+1); with clk = q*b + r this is
// floor(r/q) > ceil((b - r)/(q+1)), i.e. r >= (ceil((b - r)/(q+1)) + 1)*q
module ubd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  ubd_pkg::ubd_ctx_t ctx,
    input  logic [25:0]       quo,
    input  logic [23:0]       rem,
    output logic              strobe,
    output ubd_pkg::ubd_out_t dout
);
    import ubd_pkg::*;

    ubd_rnd_t    rin, rout;
    logic        r_vld;
    logic [23:0] k_quo;
    logic [8:0]  k_rem;
    logic        v1_reg, v2_reg;
    ubd_rnd_t    c1_reg;
    logic [32:0] lim_reg;
    ubd_out_t    out_reg, out_next;
    logic [24:0] k_up;
    logic [7:0]  qf;

    always_comb
    begin
        rin.ctx = ctx;
        rin.bad = (ctx.baud == 24'd0) || (quo == 26'd0) || (quo >= 26'(FACTOR_LIMIT));
        rin.q   = quo[7:0];
        rin.r   = rem;
    end

    // (b - r)/(q + 1) for the upper distance
    ubd_div #(.NW(24), .DW(9), .CW($bits(ubd_rnd_t))) u_rnd_div (
        .clk(clk), .rst_n(rst_n), .in_vld(in_vld), .num(ctx.baud - rem),
        .den({1'b0, quo[7:0]} + 9'd1), .in_ctx(rin), .out_vld(r_vld),
        .quo(k_quo), .rem(k_rem), .out_ctx(rout)
    );

    always_comb
    begin
        k_up = {1'b0, k_quo} + {24'd0, (k_rem != 9'd0)} + 25'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= r_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg  <= rout;
        lim_reg <= {8'd0, k_up} * {25'd0, rout.q};
        out_reg <= out_next;
    end

    always_comb
    begin
        qf = c1_reg.q + {7'd0, ({9'd0, c1_reg.r} >= lim_reg)};
        out_next.request_code = c1_reg.ctx.code;
        if (c1_reg.ctx.mode != MODE_LINE)
        begin
            out_next.request_code  = c1_reg.ctx.code + CODE_MODEM_ADD;
            out_next.request_value = MODEM_VALUE;
            out_next.request_index = 16'd0;
            out_next.valid_res     = 1'b1;
        end
        else if (c1_reg.bad)
        begin
            out_next.request_value = 16'd0;
            out_next.request_index = 16'd0;
            out_next.valid_res     = 1'b0;
        end
        else
        begin
            out_next.request_value = {c1_reg.ctx.ctl, VALUE_LOW};
            out_next.request_index = {8'd0 - qf, 5'd0, c1_reg.ctx.band};
            out_next.valid_res     = 1'b1;
        end
    end

    assign strobe = v2_reg;
    assign dout   = out_reg;
endmodule

// ----- rtl/core/uart_baud_divisor_line_setup.sv -----
// Line-setup request builder. One word is accepted every cycle (busy is tied
// low); each result passes through one stage for band choice, 26 stages of
// the bit-per-stage reference-clock divider, 24 stages of the rounding
// divider, one for the rounding product and one output register.
// The receiver cannot stall; the result is shown on done/result for one cycle.
module uart_baud_divisor_line_setup #(
    parameter int BASE_CLOCK_HZ = 12000000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ubd_pkg::ubd_in_t  cmd,
    output logic              done,
    output ubd_pkg::ubd_out_t result
);
    import ubd_pkg::*;

    logic        f_vld, d_vld;
    ubd_ctx_t    f_ctx, d_ctx;
    logic [25:0] f_clk, d_quo;
    logic [23:0] d_rem;

    assign busy = 1'b0;

    ubd_front #(.BASE_CLOCK_HZ(BASE_CLOCK_HZ)) u_front (
        .clk(clk), .rst_n(rst_n), .in_vld(start), .din(cmd),
        .out_vld(f_vld), .ctx(f_ctx), .clk_div(f_clk)
    );

    ubd_div #(.NW(26), .DW(24), .CW($bits(ubd_ctx_t))) u_div (
        .clk(clk), .rst_n(rst_n), .in_vld(f_vld), .num(f_clk), .den(f_ctx.baud),
        .in_ctx(f_ctx), .out_vld(d_vld), .quo(d_quo), .rem(d_rem), .out_ctx(d_ctx)
    );

    ubd_back u_back (
        .clk(clk), .rst_n(rst_n), .in_vld(d_vld), .ctx(d_ctx), .quo(d_quo),
        .rem(d_rem), .strobe(done), .dout(result)
    );
endmodule

// ----- verif/uart_baud_divisor_line_setup_checker.sv -----
module uart_baud_divisor_line_setup_checker
    import ubd_pkg::*;
#(
    parameter int BASE_CLOCK_HZ = 12000000
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  ubd_in_t  cmd,
    input  logic     done,
    input  ubd_out_t result,
    output int       fail_count,
    output int       pending,
    output int       request_count
);
    timeunit 1ns;
    timeprecision 1ps;

    ubd_out_t expected_requests[$];

    function automatic ubd_out_t build_request(ubd_in_t w);
        ubd_out_t r;
        logic [7:0] code;
        logic [2:0] band;
        logic [31:0] ref_clk;
        logic [31:0] baud;
        logic [31:0] q;
        logic [7:0] ctl;
        code = CODE_BASE + 8'(w.channel_number);
        if (w.channel_number >= 2'd2)
            code = code + CODE_HIGH_ADD;
        r = '0;
        if (w.mode != MODE_LINE)
        begin
            r.request_code = code + CODE_MODEM_ADD;
            r.request_value = MODEM_VALUE;
            r.valid_res = 1'b1;
            return r;
        end
        r.request_code = code;
        baud = 32'(w.line_rate);
        band = BAND_7;
        ref_clk = 32'(BASE_CLOCK_HZ);
        if (baud < 256000)
        begin
            if (baud > (BASE_CLOCK_HZ / 2) / 255)
            begin
                band = BAND_3;
                ref_clk = 32'(BASE_CLOCK_HZ / 2);
            end
            else if (baud > (BASE_CLOCK_HZ / 16) / 255)
            begin
                band = BAND_2;
                ref_clk = 32'(BASE_CLOCK_HZ / 16);
            end
            else if (baud > (BASE_CLOCK_HZ / 128) / 255)
            begin
                band = BAND_1;
                ref_clk = 32'(BASE_CLOCK_HZ / 128);
            end
            else
            begin
                band = BAND_0;
                ref_clk = 32'((BASE_CLOCK_HZ + 512) / 1024);
            end
        end
        if (baud == 0)
            return r;
        q = ref_clk / baud;
        if (q == 0 || q >= 255)
            return r;
        // round toward the nearer achievable rate
        if ((ref_clk / q - baud) > (baud - ref_clk / (q + 1)))
            q = q + 1;
        ctl = CTL_BASE;
        if (w.two_stop_bits)
            ctl = ctl | 8'h04;
        if (w.parity_kind != 3'd0)
            ctl = ctl | 8'h08 | {2'b00, 2'(w.parity_kind - 3'd1), 4'h0};
        ctl = ctl | {6'b0, 2'(w.data_bit_count - 4'd5)};
        r.request_value = {ctl, VALUE_LOW};
        r.request_index = {8'(256 - q), 5'b0, band};
        r.valid_res = 1'b1;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        request_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        ubd_out_t exp_req;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_requests.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    exp_req = expected_requests.pop_front();
                    request_count++;
                    if (exp_req.request_code !== result.request_code ||
                        exp_req.request_value !== result.request_value ||
                        exp_req.request_index !== result.request_index ||
                        exp_req.valid_res !== result.valid_res)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time,
                                 exp_req, result);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_requests.push_back(build_request(cmd));
            pending = expected_requests.size();
        end
    end
endmodule

// ----- verif/uart_baud_divisor_line_setup_test.sv -----
module uart_baud_divisor_line_setup_test;
    import ubd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = $bits(ubd_in_t);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ubd_in_t cmd;
    logic done;
    ubd_out_t result;
    int fail_count;
    int pending;
    int request_count;
    int idle_pct;
    int drain;

    uart_baud_divisor_line_setup u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .done(done), .result(result)
    );

    uart_baud_divisor_line_setup_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .fail_count(fail_count),
        .pending(pending), .request_count(request_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // drive one word, holding start until accepted
    task automatic send_word(ubd_in_t w);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic ubd_in_t random_word();
        ubd_in_t w;
        w = ubd_in_t'(IN_W'({$urandom, $urandom}));
        w.mode = ($urandom_range(9) == 0);
        case ($urandom_range(5))
            0: w.line_rate = 24'($urandom_range(300));
            1: w.line_rate = 24'($urandom_range(12000));
            2: w.line_rate = 24'($urandom_range(256000));
            3: w.line_rate = 24'($urandom_range(255990, 256010));
            4: w.line_rate = 24'($urandom_range(3000000));
            default: w.line_rate = 24'($urandom);
        endcase
        if ($urandom_range(3) != 0)
        begin
            w.parity_kind = 3'($urandom_range(4));
            w.data_bit_count = 4'($urandom_range(5, 8));
        end
        return w;
    endfunction

    initial
    begin
        ubd_in_t w;
        int bauds[$];
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // rate extremes: zero, band edges, factor limits, top of field
        bauds = '{0, 1, 45, 46, 91, 92, 183, 184, 367, 368, 23529, 23530,
                  47058, 47059, 255999, 256000, 6000000, 12000000, 12000001,
                  16777215, 9600, 115200};
        foreach (bauds[i])
        begin
            w = '0;
            w.line_rate = 24'(bauds[i]);
            w.channel_number = 2'(i % 4);
            w.two_stop_bits = 1'(i % 2);
            w.parity_kind = 3'(i % 8);
            w.data_bit_count = 4'((i * 3) % 16);
            send_word(w);
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            w = '1;
            w.mode = 1'b1;
            w.channel_number = 2'(ch);
            send_word(w);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 78 : (phase == 3 ? 38 : 0);
            repeat (375)
                send_word(random_word());
        end
        start <= 1'b0;

        drain = 0;
        while ((pending != 0 || drain < 40) && drain < 2000)
        begin
            @(posedge clk);
            if (pending == 0)
                drain++;
        end
        $display("covered %0d requests: rate bands, factor limits, modem requests,",
                 request_count);
        $display("framing wrap cases and sender idling from none to heavy");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/ubd_pkg.sv
rtl/core/ubd_div.sv
rtl/core/ubd_front.sv
rtl/core/ubd_back.sv
rtl/core/uart_baud_divisor_line_setup.sv
verif/uart_baud_divisor_line_setup_checker.sv
verif/uart_baud_divisor_line_setup_test.sv
